// ----- hw/rtl/jpc_pkg.sv -----
`default_nettype none

package jpc_pkg;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned MAX_RESULTS = 6;
  localparam int unsigned IDX_W = $clog2(MAX_RESULTS);

  localparam logic [8:0] FEED_MIN = 9'd20;
  localparam logic [8:0] FEED_MAX = 9'd500;
  localparam logic [8:0] FEED_STEP = 9'd20;
  localparam logic [8:0] FEED_RESET = 9'd240;
  localparam logic [8:0] PULSE_FEED = 9'd200;
  localparam logic [2:0] MODE_CONT = 3'd0;
  localparam logic [2:0] MODE_MAX = 3'd4;
  localparam logic [15:0] IDLE_MAX = 16'hFFFF;
  localparam logic signed [15:0] PRESS_LEVEL = 16'sd1000;

  localparam logic [11:0] X_CENTER_RESET = 12'd2048;
  localparam logic [11:0] Y_CENTER_RESET = 12'd2048;
  localparam logic [11:0] DEADZONE_RESET = 12'd100;
  localparam logic [15:0] IDLE_TIMEOUT_RESET = 16'd15000;

  typedef enum logic [2:0] {
    CFG_JOYSTICK_DIGITAL = 3'd0,
    CFG_X_CENTER         = 3'd1,
    CFG_Y_CENTER         = 3'd2,
    CFG_DEADZONE         = 3'd3,
    CFG_IDLE_TIMEOUT     = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    KEY_NONE      = 3'd0,
    KEY_MODE_NEXT = 3'd1,
    KEY_MODE_PREV = 3'd2,
    KEY_FEED_UP   = 3'd3,
    KEY_FEED_DOWN = 3'd4,
    KEY_SET_X     = 3'd5,
    KEY_SET_Z     = 3'd6
  } key_e;

  typedef enum logic [2:0] {
    KIND_STATUS = 3'd0,
    KIND_MOVE   = 3'd1,
    KIND_CANCEL = 3'd2,
    KIND_DWELL  = 3'd3,
    KIND_SET    = 3'd4,
    KIND_EXIT   = 3'd5
  } kind_e;

  typedef struct packed {
    logic signed [15:0] adc_ch0;
    logic signed [15:0] adc_ch1;
    logic signed [15:0] adc_ch2;
    logic signed [15:0] adc_ch3;
    logic [2:0]         key_code;
    logic [9:0]         elapsed_ms;
  } poll_t;

  typedef struct packed {
    kind_e      kind;
    logic       axis;
    logic       negative;
    logic [2:0] distance_code;
    logic [8:0] feed_rate;
    logic [3:0] direction_bits;
    logic [2:0] step_mode;
    logic       last;
  } result_t;

  typedef struct packed {
    logic        joystick_digital;
    logic [11:0] x_center;
    logic [11:0] y_center;
    logic [11:0] deadzone;
    logic [15:0] idle_timeout_ms;
  } cfg_t;

  typedef struct packed {
    logic [3:0] dirs;
    logic [2:0] key_code;
    logic [9:0] elapsed_ms;
  } sensed_t;

  typedef struct packed {
    logic [3:0] dirs;
    logic [2:0] mode;
    logic [8:0] status_feed;
    logic       timeout;
    logic       set_req;
    logic       set_axis;
    logic       move;
    logic       move_axis;
    logic       move_neg;
    logic [2:0] move_dist;
    logic [8:0] move_feed;
    logic       move_dwell;
    logic       release_seq;
  } rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/jpc_sense.sv -----
`default_nettype none

module jpc_sense import jpc_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    accept_i,
  input  wire logic    fire_i,
  input  wire poll_t   poll_i,
  input  wire cfg_t    cfg_i,
  output logic         valid_o,
  output sensed_t      sensed_o
);

  function automatic logic [29:0] times_4095(input logic [15:0] u);
    return {2'b0, u, 12'b0} - {14'b0, u};
  endfunction

  function automatic logic [29:0] times_65535(input logic [12:0] t);
    return {1'b0, t, 16'b0} - {17'b0, t};
  endfunction

  logic        valid_q, valid_d;
  sensed_t     sensed_q;
  logic [3:0]  dirs_dig, dirs_ana, dirs;
  logic [29:0] ax, ay;
  logic [12:0] x_lo, x_hi, y_lo, y_hi;

  always_comb begin
    dirs_dig[0] = $signed(poll_i.adc_ch2) < PRESS_LEVEL;
    dirs_dig[1] = $signed(poll_i.adc_ch0) < PRESS_LEVEL;
    dirs_dig[2] = $signed(poll_i.adc_ch1) < PRESS_LEVEL;
    dirs_dig[3] = $signed(poll_i.adc_ch3) < PRESS_LEVEL;

    ax = times_4095({~poll_i.adc_ch2[15], poll_i.adc_ch2[14:0]});
    ay = times_4095({~poll_i.adc_ch3[15], poll_i.adc_ch3[14:0]});
    x_lo = {1'b0, cfg_i.x_center} - {1'b0, cfg_i.deadzone};
    x_hi = {1'b0, cfg_i.x_center} + {1'b0, cfg_i.deadzone};
    y_lo = {1'b0, cfg_i.y_center} - {1'b0, cfg_i.deadzone};
    y_hi = {1'b0, cfg_i.y_center} + {1'b0, cfg_i.deadzone};

    dirs_ana[0] = !x_lo[12] && (ax < times_65535(x_lo + 13'd1));
    dirs_ana[1] = ax >= times_65535(x_hi);
    dirs_ana[2] = !y_lo[12] && (ay < times_65535(y_lo + 13'd1));
    dirs_ana[3] = ay >= times_65535(y_hi);

    dirs = cfg_i.joystick_digital ? dirs_dig : dirs_ana;
  end

  always_comb begin
    valid_d = valid_q;
    if (accept_i) begin
      valid_d = 1'b1;
    end else if (fire_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      sensed_q.dirs       <= dirs;
      sensed_q.key_code   <= poll_i.key_code;
      sensed_q.elapsed_ms <= poll_i.elapsed_ms;
    end
  end

  assign valid_o  = valid_q;
  assign sensed_o = sensed_q;

endmodule

`default_nettype wire

// ----- hw/rtl/jpc_front.sv -----
`default_nettype none

module jpc_front import jpc_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        fire_i,
  input  wire sensed_t     sensed_i,
  input  wire logic [15:0] idle_timeout_i,
  output rec_t             rec_o
);

  logic [2:0]  mode_q, mode_d;
  logic [8:0]  feed_q, feed_d;
  logic        await_q, await_d;
  logic        active_q, active_d;
  logic [15:0] idle_q, idle_d;

  logic [16:0] idle_sum;
  logic [15:0] idle_acc;
  logic [9:0]  feed_up;
  logic        single, sel_axis, sel_neg;
  logic [3:0]  dirs;
  rec_t        rec;

  always_comb begin
    dirs = sensed_i.dirs;
    single = 1'b1;
    sel_axis = 1'b0;
    sel_neg = 1'b0;
    unique case (dirs)
      4'b0001: begin
        sel_axis = 1'b0;
        sel_neg  = 1'b0;
      end
      4'b0010: begin
        sel_axis = 1'b0;
        sel_neg  = 1'b1;
      end
      4'b0100: begin
        sel_axis = 1'b1;
        sel_neg  = 1'b1;
      end
      4'b1000: begin
        sel_axis = 1'b1;
        sel_neg  = 1'b0;
      end
      default: single = 1'b0;
    endcase

    idle_sum = {1'b0, idle_q} + {7'b0, sensed_i.elapsed_ms};
    idle_acc = idle_sum[16] ? IDLE_MAX : idle_sum[15:0];
    if (dirs != 4'd0) begin
      idle_acc = 16'd0;
    end
    feed_up = {1'b0, feed_q} + {1'b0, FEED_STEP};

    mode_d   = mode_q;
    feed_d   = feed_q;
    await_d  = await_q;
    active_d = active_q;
    idle_d   = idle_acc;

    rec             = '0;
    rec.dirs        = dirs;
    rec.mode        = mode_q;
    rec.status_feed = feed_q;

    if (idle_acc > idle_timeout_i) begin
      rec.timeout = 1'b1;
      idle_d = 16'd0;
      mode_d = MODE_CONT;
      feed_d = FEED_RESET;
    end else begin
      if (sensed_i.key_code != KEY_NONE) begin
        idle_d = 16'd0;
      end
      unique case (sensed_i.key_code)
        KEY_MODE_NEXT: mode_d = (mode_q == MODE_MAX) ? MODE_CONT : mode_q + 3'd1;
        KEY_MODE_PREV: mode_d = (mode_q == MODE_CONT) ? MODE_MAX : mode_q - 3'd1;
        KEY_FEED_UP:   feed_d = (feed_up > {1'b0, FEED_MAX}) ? FEED_MAX : feed_up[8:0];
        KEY_FEED_DOWN: feed_d = (feed_q < FEED_MIN + FEED_STEP) ? FEED_MIN : feed_q - FEED_STEP;
        KEY_SET_X: begin
          rec.set_req  = 1'b1;
          rec.set_axis = 1'b0;
        end
        KEY_SET_Z: begin
          rec.set_req  = 1'b1;
          rec.set_axis = 1'b1;
        end
        default: ;
      endcase
      rec.mode        = mode_d;
      rec.status_feed = feed_d;
      rec.move_axis   = sel_axis;
      rec.move_neg    = sel_neg;

      if (mode_d != MODE_CONT) begin
        if (await_q) begin
          if (dirs == 4'd0) begin
            await_d = 1'b0;
          end
        end else if (single) begin
          rec.move       = 1'b1;
          rec.move_dist  = mode_d;
          rec.move_feed  = PULSE_FEED;
          rec.move_dwell = 1'b1;
          await_d        = 1'b1;
        end
      end else begin
        if (dirs == 4'd0) begin
          rec.release_seq = active_q;
          active_d = 1'b0;
        end else if (!active_q && single) begin
          rec.move      = 1'b1;
          rec.move_dist = 3'd0;
          rec.move_feed = feed_d;
          active_d      = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_CONT;
      feed_q   <= FEED_RESET;
      await_q  <= 1'b0;
      active_q <= 1'b0;
      idle_q   <= 16'd0;
    end else if (fire_i) begin
      mode_q   <= mode_d;
      feed_q   <= feed_d;
      await_q  <= await_d;
      active_q <= active_d;
      idle_q   <= idle_d;
    end
  end

  assign rec_o = rec;

endmodule

`default_nettype wire

// ----- hw/rtl/jpc_fifo.sv -----
`default_nettype none

module jpc_fifo import jpc_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire rec_t  wdata_i,
  input  wire logic  pop_i,
  output rec_t       rdata_o,
  output fifo_status_t status_o
);

  localparam int unsigned PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(FIFO_DEPTH - 1);

  rec_t             entries_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign status_o.full  = (cnt_q == CNT_W'(FIFO_DEPTH));
  assign status_o.empty = (cnt_q == '0);
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == LAST_PTR) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == LAST_PTR) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wptr_q] <= wdata_i;
    end
  end

  assign rdata_o = entries_q[rptr_q];

endmodule

`default_nettype wire

// ----- hw/rtl/jpc_back.sv -----
`default_nettype none

module jpc_back import jpc_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire rec_t  rec_i,
  input  wire logic  rec_avail_i,
  output logic       rec_take_o,
  input  wire logic  pop_i,
  output logic       empty_o,
  output result_t    item_o
);

  rec_t             rec_q;
  logic             vld_q, vld_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  kind_e            kinds [MAX_RESULTS];
  logic [IDX_W-1:0] cnt;
  logic             is_last, load;
  result_t          item;

  always_comb begin
    for (int i = 0; i < MAX_RESULTS; i++) begin
      kinds[i] = KIND_STATUS;
    end
    cnt = IDX_W'(1);
    if (rec_q.timeout) begin
      kinds[1] = KIND_CANCEL;
      kinds[2] = KIND_EXIT;
      cnt = IDX_W'(3);
    end else begin
      if (rec_q.set_req) begin
        kinds[cnt]          = KIND_CANCEL;
        kinds[cnt + 1'b1]   = KIND_SET;
        cnt = cnt + IDX_W'(2);
      end
      if (rec_q.move) begin
        kinds[cnt] = KIND_MOVE;
        cnt = cnt + 1'b1;
        if (rec_q.move_dwell) begin
          kinds[cnt] = KIND_DWELL;
          cnt = cnt + 1'b1;
        end
      end
      if (rec_q.release_seq) begin
        kinds[cnt]              = KIND_CANCEL;
        kinds[cnt + 1'b1]       = KIND_DWELL;
        kinds[cnt + IDX_W'(2)]  = KIND_CANCEL;
        cnt = cnt + IDX_W'(3);
      end
    end
  end

  assign is_last = (idx_q == cnt - 1'b1);

  always_comb begin
    item                = '0;
    item.kind           = kinds[idx_q];
    item.direction_bits = rec_q.dirs;
    item.step_mode      = rec_q.mode;
    item.last           = is_last;
    unique case (item.kind)
      KIND_STATUS: item.feed_rate = rec_q.status_feed;
      KIND_MOVE: begin
        item.axis          = rec_q.move_axis;
        item.negative      = rec_q.move_neg;
        item.distance_code = rec_q.move_dist;
        item.feed_rate     = rec_q.move_feed;
      end
      KIND_SET: item.axis = rec_q.set_axis;
      default: ;
    endcase
  end

  assign load       = !vld_q || (pop_i && is_last);
  assign rec_take_o = load && rec_avail_i;

  always_comb begin
    vld_d = vld_q;
    idx_d = idx_q;
    if (load) begin
      vld_d = rec_avail_i;
      idx_d = '0;
    end else if (pop_i) begin
      idx_d = idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      idx_q <= '0;
    end else begin
      vld_q <= vld_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rec_take_o) begin
      rec_q <= rec_i;
    end
  end

  assign empty_o = !vld_q;
  assign item_o  = item;

endmodule

`default_nettype wire

// ----- hw/rtl/jog_pendant_controller_top.sv -----
`default_nettype none
// A poll passes the sense register, then the command queue, then the sequencer register.
// Throughput: one poll per cycle into the command queue while it is not full; the
// sequencer shows one result per cycle while pop is held; a poll has 1 to 6 results.
// Reset: rst_ni is asynchronous and active low; it restores the control registers,
// configuration and jog state (continuous mode, feed 240) at once; empties the queue.

module jog_pendant_controller_top import jpc_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire poll_t       in_item_i,
  output logic             empty,
  input  wire logic        pop,
  output result_t          out_item_o,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_addr_i,
  input  wire logic [15:0] cfg_wdata_i
);

  cfg_t         cfg_q;
  logic         accept, fire, sense_vld, rec_take;
  sensed_t      sensed;
  rec_t         rec_in, rec_out;
  fifo_status_t fifo_st;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.joystick_digital <= 1'b0;
      cfg_q.x_center         <= X_CENTER_RESET;
      cfg_q.y_center         <= Y_CENTER_RESET;
      cfg_q.deadzone         <= DEADZONE_RESET;
      cfg_q.idle_timeout_ms  <= IDLE_TIMEOUT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_JOYSTICK_DIGITAL: cfg_q.joystick_digital <= cfg_wdata_i[0];
        CFG_X_CENTER:         cfg_q.x_center         <= cfg_wdata_i[11:0];
        CFG_Y_CENTER:         cfg_q.y_center         <= cfg_wdata_i[11:0];
        CFG_DEADZONE:         cfg_q.deadzone         <= cfg_wdata_i[11:0];
        CFG_IDLE_TIMEOUT:     cfg_q.idle_timeout_ms  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign full   = sense_vld && fifo_st.full;
  assign accept = push && !full;
  assign fire   = sense_vld && !fifo_st.full;

  jpc_sense u_sense (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .fire_i   (fire),
    .poll_i   (in_item_i),
    .cfg_i    (cfg_q),
    .valid_o  (sense_vld),
    .sensed_o (sensed)
  );

  jpc_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fire_i         (fire),
    .sensed_i       (sensed),
    .idle_timeout_i (cfg_q.idle_timeout_ms),
    .rec_o          (rec_in)
  );

  jpc_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (fire),
    .wdata_i  (rec_in),
    .pop_i    (rec_take),
    .rdata_o  (rec_out),
    .status_o (fifo_st)
  );

  jpc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rec_i       (rec_out),
    .rec_avail_i (!fifo_st.empty),
    .rec_take_o  (rec_take),
    .pop_i       (pop),
    .empty_o     (empty),
    .item_o      (out_item_o)
  );

  a_exit_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_item_o.kind == KIND_EXIT) |-> out_item_o.last)
    else $error("scene exit not the final result of its poll");

  a_move_dist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_item_o.kind == KIND_MOVE) |-> out_item_o.distance_code == out_item_o.step_mode)
    else $error("move distance does not follow step mode");

  a_pulse_feed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_item_o.kind == KIND_MOVE && out_item_o.step_mode != MODE_CONT)
      |-> out_item_o.feed_rate == PULSE_FEED)
    else $error("pulse move with wrong feed");

  a_status_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(pop && !empty && out_item_o.last) && !empty) |-> out_item_o.kind == KIND_STATUS)
    else $error("poll results do not start with a status");

endmodule

`default_nettype wire
